/* hdl/assert_macros.svh */
// ============================================================================
// Assertion macros
// Shared wrappers for concurrent assertions clocked on clk and reset by rst_n.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge of clk while rst_n is high.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true at a rising edge of clk outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    `ASSERT_ALWAYS(label, !(expr), msg)

`endif

/* hdl/efla_pkg.sv */
// ============================================================================
// Extent free-list allocator package
// Types, codes and constants shared by the allocator modules and its checker.
// ============================================================================
package efla_pkg;

    // Blocks in the volume store, including reserved block zero.
    localparam int NBLOCKS = 1024;

    // Field widths fixed by the interface.
    localparam int BLK_W = 10;
    localparam int VOL_W = 11;
    localparam int MEM_W = 2 * BLK_W;

    localparam logic [VOL_W-1:0] NBLOCKS_V  = VOL_W'(NBLOCKS);
    localparam logic [VOL_W-1:0] VOL_RESET  = VOL_W'(1024);
    localparam logic [BLK_W-1:0] FREE_MAX   = BLK_W'(NBLOCKS - 1);
    localparam logic [BLK_W-1:0] FIRST_BLK  = BLK_W'(1);

    typedef enum logic [1:0] {
        KIND_FORMAT  = 2'd0,
        KIND_ALLOC   = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_NOP     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_FREE  = 2'd1,
        STATUS_RESERVED = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        kind_t            kind;
        logic [BLK_W-1:0] block;
    } req_t;

    typedef struct packed {
        logic [BLK_W-1:0] granted_block;
        status_t          status;
        logic [BLK_W-1:0] free_count;
    } rsp_t;

    // Extent record store access: read port and write port.
    typedef struct packed {
        logic             rd_en;
        logic [BLK_W-1:0] rd_addr;
        logic             wr_en;
        logic [BLK_W-1:0] wr_addr;
        logic [MEM_W-1:0] wr_data;
    } mem_req_t;

endpackage

/* hdl/efla_ram.sv */
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module efla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hdl/efla_ctrl.sv */
// ============================================================================
// Extent free-list allocator control
// Sequencer, head and count registers, record update logic and result register.
// ============================================================================
module efla_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  efla_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output efla_pkg::rsp_t                rsp,
    input  logic                          cfg_wr_en,
    input  logic [efla_pkg::VOL_W-1:0]    cfg_wr_data,
    output efla_pkg::mem_req_t            mem_req,
    input  logic [efla_pkg::MEM_W-1:0]    mem_rd_data
);
    import efla_pkg::*;

    state_t           state_reg, state_next;
    req_t             op_reg;
    logic [BLK_W-1:0] head_reg, head_next;
    logic [BLK_W-1:0] free_reg, free_next;
    logic [VOL_W-1:0] vol_reg;
    rsp_t             rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic             accept;
    logic [BLK_W-1:0] rd_size, rd_link;
    logic [VOL_W-1:0] vol_clamp, vol_clamp_m1;
    logic [BLK_W-1:0] fmt_free;
    logic [VOL_W-1:0] head_up;
    logic [BLK_W-1:0] granted;
    status_t          status;

    // A new item is taken only when the result register will be empty by the
    // time this item's result is written.
    assign req_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;

    assign rd_size = mem_rd_data[MEM_W-1:BLK_W];
    assign rd_link = mem_rd_data[BLK_W-1:0];

    assign vol_clamp    = (vol_reg > NBLOCKS_V) ? NBLOCKS_V : vol_reg;
    assign vol_clamp_m1 = vol_clamp - VOL_W'(1);
    assign fmt_free     = (vol_clamp == '0) ? '0 : vol_clamp_m1[BLK_W-1:0];
    assign head_up      = {1'b0, head_reg} + VOL_W'(1);

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        free_next       = free_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        granted         = '0;
        status          = STATUS_OK;
        mem_req.rd_en   = accept;
        mem_req.rd_addr = head_reg;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = head_reg;
        mem_req.wr_data = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                case (op_reg.kind)
                    KIND_FORMAT:
                    begin
                        free_next       = fmt_free;
                        head_next       = FIRST_BLK;
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = FIRST_BLK;
                        mem_req.wr_data = {fmt_free, BLK_W'(0)};
                    end
                    KIND_ALLOC:
                    begin
                        if (free_reg == '0)
                        begin
                            status = STATUS_NO_FREE;
                        end
                        else
                        begin
                            granted   = head_reg;
                            free_next = free_reg - BLK_W'(1);
                            if (rd_size <= BLK_W'(1))
                            begin
                                head_next = rd_link;
                            end
                            else
                            begin
                                // Shrink the extent by moving its record one block up.
                                head_next       = head_up[BLK_W-1:0];
                                mem_req.wr_en   = (head_up < NBLOCKS_V);
                                mem_req.wr_addr = head_up[BLK_W-1:0];
                                mem_req.wr_data = {rd_size - BLK_W'(1), rd_link};
                            end
                        end
                    end
                    KIND_RELEASE:
                    begin
                        if (op_reg.block == '0)
                        begin
                            status = STATUS_RESERVED;
                        end
                        else if ({1'b0, op_reg.block} < vol_clamp)
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = op_reg.block;
                            mem_req.wr_data = {FIRST_BLK, head_reg};
                            head_next       = op_reg.block;
                            if (free_reg < FREE_MAX)
                            begin
                                free_next = free_reg + BLK_W'(1);
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
                rsp_next = '{granted_block: granted, status: status, free_count: free_next};
                rsp_valid_next = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= FIRST_BLK;
            free_reg      <= '0;
            vol_reg       <= VOL_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            free_reg      <= free_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                vol_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

endmodule

/* hdl/extent_free_list_block_allocator_top.sv */
// ============================================================================
// Extent free-list block allocator
// Hands out and takes back blocks of one volume from a list of free extents.
// ============================================================================
// In the cycle a request beat is accepted, the record of the current head
// extent is read from the extent store, a single-port-read, single-port-write
// RAM with registered read data, and in the next cycle the record is updated
// and written back, the head and free count registers move and the response
// is loaded into the output register; no new request is taken in between.
// While an earlier response still waits in the output register, a new
// request is taken only in a cycle in which that response is taken too.
// Format builds one extent over blocks 1 to N-1, where N is volume_blocks
// clamped to the store depth. Allocate returns the head block; release
// pushes a block below N as a one-block extent. Allocating with no free
// block, or releasing block zero, returns an error status with granted_block
// zero. The extent store is not cleared: its entries hold nothing meaningful
// until a format or a release writes them. The user must write volume_blocks
// through cfg_wr_en and cfg_wr_data only while no request is in flight; the
// block itself does not enforce this.
module extent_free_list_block_allocator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  efla_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output efla_pkg::rsp_t                rsp,
    input  logic                          cfg_wr_en,
    input  logic [efla_pkg::VOL_W-1:0]    cfg_wr_data
);
    import efla_pkg::*;

    mem_req_t         mem_req;
    logic [MEM_W-1:0] mem_rd_data;

    // Sequencer and registers around the store.
    efla_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data)
    );

    // Extent store: each entry holds {size, link} for the extent starting there.
    efla_ram #(
        .WIDTH (MEM_W),
        .DEPTH (NBLOCKS)
    ) u_extent_ram (
        .clk     (clk),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data)
    );

endmodule

/* hdl/efla_chk.sv */
// ============================================================================
// Extent free-list allocator checker
// Port-level assertions on the allocator top level, attached by bind.
// ============================================================================
`include "assert_macros.svh"

module efla_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input efla_pkg::req_t                req,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input efla_pkg::rsp_t                rsp,
    input logic                          cfg_wr_en,
    input logic [efla_pkg::VOL_W-1:0]    cfg_wr_data
);
    import efla_pkg::*;

    // A stalled response beat holds its payload.
    `ASSERT_ALWAYS(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "response changed while stalled")

    // After a request is taken, the output is empty and no second request is taken.
    `ASSERT_ALWAYS(a_busy_after_req, req_valid && req_ready |=> !rsp_valid && !req_ready, "request overlap")

    // Every accepted request yields its response after its execute state.
    `ASSERT_ALWAYS(a_rsp_latency, req_valid && req_ready |-> ##2 rsp_valid, "response missing")

    // An error response never grants a block.
    `ASSERT_NEVER(a_err_no_grant, rsp_valid && rsp.status != STATUS_OK && rsp.granted_block != '0, "error response granted a block")

endmodule

bind extent_free_list_block_allocator_top efla_chk u_efla_chk (.*);
